// File: hw/rtl/clns_pkg.sv
`timescale 1ns / 1ps

package clns_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int STORE_DEPTH   = 64;
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 7;
    localparam int WORD_W        = 128;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_HIT  = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;
    localparam logic [1:0] KIND_FULL = 2'd3;

    localparam logic REG_CELL_WIDTH  = 1'b0;
    localparam logic REG_CELL_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic [30:0]        search_radius;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] neighbor_index;
        logic [CNT_W-1:0] stored_count;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic signed [31:0] dividend;
        logic [30:0]        divisor;
    } div_req_t;

endpackage

// File: hw/rtl/cell_list_neighbor_search.sv
`timescale 1ns / 1ps

// 2D cell-list neighbor search over up to MAX_PARTICLES stored particles.
// req channel (valid/ready) takes one item: clear, add particle or query.
// rsp channel (valid/ready) returns the result items; last marks the final one.
// cfg_we/cfg_index/cfg_data write cell_width and cell_height (0 acts as 1).
// One item at a time: req_ready is high only while the sequencer is idle.
// Clear and unused opcodes: answered from the idle state through S_OUT.
// Add: two passes of the shared divider (x, then y), then the store write.
// Query: two divider passes, then every stored particle is read for each
//   of the nine cells around the query cell, paced by the single store read
//   port and the shared squarer.
// A hit is held one step so the last flag is known; each emit waits for a
// free output register, so a stalled receiver holds the sequencer in place.
// Reset empties the store (count 0), restores cell sizes to 1.0 and
// drops any pending response.
module cell_list_neighbor_search (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  clns_pkg::in_item_t   req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output clns_pkg::out_item_t  rsp,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [30:0]          cfg_data
);
    import clns_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_OUT   = 15'b000000000000010,
        S_DXS   = 15'b000000000000100,
        S_DXW   = 15'b000000000001000,
        S_DYS   = 15'b000000000010000,
        S_DYW   = 15'b000000000100000,
        S_WR    = 15'b000000001000000,
        S_R2    = 15'b000000010000000,
        S_RD    = 15'b000000100000000,
        S_CMP   = 15'b000001000000000,
        S_SQX   = 15'b000010000000000,
        S_SQY   = 15'b000100000000000,
        S_TEST  = 15'b001000000000000,
        S_EMITP = 15'b010000000000000,
        S_FIN   = 15'b100000000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [30:0]        cw_reg, cw_next, ch_reg, ch_next;
    logic               query_reg, query_next;
    logic signed [31:0] x_reg, x_next, y_reg, y_next;
    logic [30:0]        r_reg, r_next;
    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [61:0]        r2_reg, r2_next;
    logic [IDX_W-1:0]   p_reg, p_next;
    logic [1:0]         ox_reg, ox_next, oy_reg, oy_next;
    logic [31:0]        dx_reg, dx_next, dy_reg, dy_next;
    logic [63:0]        sx_reg, sx_next, sy_reg, sy_next;
    logic [IDX_W-1:0]   pend_reg, pend_next;
    logic               have_reg, have_next;
    out_item_t          res_reg, res_next;
    logic               rsp_valid_reg, rsp_valid_next;
    out_item_t          rsp_reg, rsp_next;

    div_req_t           div_req;
    logic               div_done;
    logic signed [31:0] div_q;

    logic               ram_we;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;
    logic signed [31:0] rd_x, rd_y, rd_cx, rd_cy;

    logic [31:0]        mul_a;
    logic [63:0]        prod;
    logic [64:0]        dsum;
    logic               hit;
    logic [33:0]        tx, ty;
    logic               cell_match;
    logic [32:0]        dxs, dys, dxa, dya;
    logic               slot_free;
    logic               last_p, last_cell;
    logic [30:0]        cw_eff, ch_eff;

    assign cw_eff    = (cw_reg == 31'd0) ? 31'd1 : cw_reg;
    assign ch_eff    = (ch_reg == 31'd0) ? 31'd1 : ch_reg;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    clns_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    clns_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (p_reg),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {x_reg, y_reg, cx_reg, cy_reg};
    assign ram_we    = (state_reg == S_WR);
    assign rd_x      = ram_rdata[127:96];
    assign rd_y      = ram_rdata[95:64];
    assign rd_cx     = ram_rdata[63:32];
    assign rd_cy     = ram_rdata[31:0];

    always_comb
    begin
        div_req.start    = (state_reg == S_DXS) || (state_reg == S_DYS);
        div_req.dividend = (state_reg == S_DYS) ? y_reg : x_reg;
        div_req.divisor  = (state_reg == S_DYS) ? ch_eff : cw_eff;
    end

    // shared squarer
    always_comb
    begin
        case (state_reg)
            S_R2:    mul_a = {1'b0, r_reg};
            S_SQY:   mul_a = dy_reg;
            default: mul_a = dx_reg;
        endcase
    end
    assign prod = mul_a * mul_a;

    assign tx = {{2{cx_reg[31]}}, cx_reg} + {32'd0, ox_reg} - 34'd1;
    assign ty = {{2{cy_reg[31]}}, cy_reg} + {32'd0, oy_reg} - 34'd1;
    assign cell_match = (tx == {{2{rd_cx[31]}}, rd_cx}) && (ty == {{2{rd_cy[31]}}, rd_cy});
    assign dxs  = {x_reg[31], x_reg} - {rd_x[31], rd_x};
    assign dys  = {y_reg[31], y_reg} - {rd_y[31], rd_y};
    assign dxa  = dxs[32] ? -dxs : dxs;
    assign dya  = dys[32] ? -dys : dys;
    assign dsum = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign hit  = dsum < {3'd0, r2_reg};

    assign last_p    = ({1'b0, p_reg} + 7'd1) == count_reg;
    assign last_cell = (ox_reg == 2'd2) && (oy_reg == 2'd2);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cw_next        = cw_reg;
        ch_next        = ch_reg;
        query_next     = query_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        r_next         = r_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        r2_next        = r2_reg;
        p_next         = p_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        pend_next      = pend_reg;
        have_next      = have_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        req_ready      = (state_reg == S_IDLE);

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            if (cfg_index == REG_CELL_WIDTH)
            begin
                cw_next = cfg_data;
            end
            else
            begin
                ch_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    x_next     = req.x_coord;
                    y_next     = req.y_coord;
                    r_next     = req.search_radius;
                    query_next = (req.opcode == OP_QUERY);
                    res_next   = '{kind: KIND_ACK, neighbor_index: '0,
                                   stored_count: count_reg, last: 1'b1};
                    case (req.opcode)
                        OP_CLEAR:
                        begin
                            count_next            = '0;
                            res_next.stored_count = '0;
                            state_next            = S_OUT;
                        end
                        OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_PARTICLES))
                            begin
                                res_next.kind = KIND_FULL;
                                state_next    = S_OUT;
                            end
                            else
                            begin
                                state_next = S_DXS;
                            end
                        end
                        OP_QUERY:
                        begin
                            have_next  = 1'b0;
                            state_next = S_DXS;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            S_DXS:
            begin
                state_next = S_DXW;
            end
            S_DXW:
            begin
                if (div_done)
                begin
                    cx_next    = div_q;
                    state_next = S_DYS;
                end
            end
            S_DYS:
            begin
                state_next = S_DYW;
            end
            S_DYW:
            begin
                if (div_done)
                begin
                    cy_next    = div_q;
                    state_next = query_reg ? S_R2 : S_WR;
                end
            end
            S_WR:
            begin
                count_next            = count_reg + 7'd1;
                res_next.stored_count = count_reg + 7'd1;
                state_next            = S_OUT;
            end
            S_R2:
            begin
                r2_next    = prod[61:0];
                p_next     = '0;
                ox_next    = 2'd0;
                oy_next    = 2'd0;
                state_next = (count_reg == '0) ? S_FIN : S_RD;
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_SQX:
            begin
                sx_next    = prod;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                sy_next    = prod;
                state_next = S_TEST;
            end
            S_FIN:
            begin
                res_next   = '{kind: have_reg ? KIND_HIT : KIND_NONE,
                               neighbor_index: have_reg ? pend_reg : '0,
                               stored_count: count_reg, last: 1'b1};
                state_next = S_OUT;
            end
            default:
            begin
            end
        endcase

        // particle walk: compare, test, flush held hit, then advance
        if ((state_reg == S_CMP) || (state_reg == S_TEST) || (state_reg == S_EMITP))
        begin
            logic advance;
            advance = 1'b0;
            if (state_reg == S_CMP)
            begin
                if (cell_match)
                begin
                    dx_next    = dxa[31:0];
                    dy_next    = dya[31:0];
                    state_next = S_SQX;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            else if (state_reg == S_TEST)
            begin
                if (hit && have_reg)
                begin
                    state_next = S_EMITP;
                end
                else
                begin
                    if (hit)
                    begin
                        pend_next = p_reg;
                        have_next = 1'b1;
                    end
                    advance = 1'b1;
                end
            end
            else if (slot_free)
            begin
                rsp_valid_next = 1'b1;
                rsp_next       = '{kind: KIND_HIT, neighbor_index: pend_reg,
                                   stored_count: count_reg, last: 1'b0};
                pend_next      = p_reg;
                advance        = 1'b1;
            end
            if (advance)
            begin
                if (!last_p)
                begin
                    p_next     = p_reg + 6'd1;
                    state_next = S_RD;
                end
                else
                begin
                    p_next = '0;
                    if (last_cell)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_RD;
                        if (oy_reg == 2'd2)
                        begin
                            oy_next = 2'd0;
                            ox_next = ox_reg + 2'd1;
                        end
                        else
                        begin
                            oy_next = oy_reg + 2'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cw_reg        <= 31'd65536;
            ch_reg        <= 31'd65536;
            rsp_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cw_reg        <= cw_next;
            ch_reg        <= ch_next;
            rsp_valid_reg <= rsp_valid_next;
            have_reg      <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg <= query_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        r_reg     <= r_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        r2_reg    <= r2_next;
        p_reg     <= p_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        pend_reg  <= pend_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: hw/rtl/clns_ram.sv
`timescale 1ns / 1ps

module clns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/clns_div.sv
`timescale 1ns / 1ps

// floor division, one quotient bit per cycle
module clns_div (
    input  logic                clk,
    input  logic                rst_n,
    input  clns_pkg::div_req_t  req,
    output logic                done,
    output logic signed [31:0]  quotient
);
    import clns_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [30:0] d_reg, d_next;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        ge;
    logic [31:0] mag;

    assign rem_sh  = {rem_reg, quo_reg[31]};
    assign ge      = rem_sh >= {2'b00, d_reg};
    assign rem_sub = rem_sh - {2'b00, d_reg};
    assign mag     = quo_reg + 32'(rem_reg != 32'd0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        d_next    = d_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            neg_next  = req.dividend[31];
            rem_next  = 32'd0;
            quo_next  = req.dividend[31] ? 32'(-req.dividend) : 32'(req.dividend);
            d_next    = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[31:0] : rem_sh[31:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(-mag) : $signed(quo_reg);

endmodule

// File: hw/rtl/clns_checker.sv
`timescale 1ns / 1ps

module clns_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input clns_pkg::out_item_t  rsp
);
    import clns_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp item changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready right after an accepted item");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind != KIND_HIT) |-> rsp.last)
        else $error("non-hit item without last");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.stored_count <= CNT_W'(MAX_PARTICLES))
        else $error("stored count above capacity");

endmodule

bind cell_list_neighbor_search clns_checker u_clns_checker (.*);

// File: sim/tb_cell_list_neighbor_search.sv
`timescale 1ns / 1ps

module tb_cell_list_neighbor_search;
    import clns_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    in_item_t    req;
    logic        rsp_valid;
    logic        rsp_ready;
    out_item_t   rsp;
    logic        cfg_we;
    logic        cfg_index;
    logic [30:0] cfg_data;

    cell_list_neighbor_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block's state
    logic [30:0]        grid_w;
    logic [30:0]        grid_h;
    logic signed [31:0] px [0:63];
    logic signed [31:0] py [0:63];
    longint             pcx [0:63];
    longint             pcy [0:63];
    int                 npart;

    out_item_t expected_results [$];
    int        errors = 0;
    int        items_sent;
    int        results_seen = 0;
    int        hits_seen = 0;
    int        full_seen = 0;
    int        hold_req = 0;
    int        hold_seen = 0;
    int        hold_cycles = 0;
    int        rx_wait = 0;
    int        rx_draw;
    logic      rsp_taken = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint cell_of(input logic signed [31:0] v, input logic [30:0] size);
        longint a;
        longint d;
        longint q;
        a = v;
        d = (size == 0) ? 1 : size;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic out_item_t mk(input logic [1:0] k, input int idx, input logic lst);
        out_item_t o;
        o.kind = k;
        o.neighbor_index = idx[5:0];
        o.stored_count = npart[6:0];
        o.last = lst;
        return o;
    endfunction

    task automatic add_expect(input out_item_t o);
        expected_results = {expected_results, o};
    endtask

    task automatic predict_results(input in_item_t it);
        longint       cx;
        longint       cy;
        logic [127:0] r2;
        logic [127:0] dx;
        logic [127:0] dy;
        logic [127:0] dsq;
        longint       a;
        longint       b;
        int           hits;
        out_item_t    o;
        case (it.opcode)
            OP_CLEAR:
            begin
                npart = 0;
                add_expect(mk(KIND_ACK, 0, 1'b1));
            end
            OP_ADD:
            begin
                if (npart >= MAX_PARTICLES)
                    add_expect(mk(KIND_FULL, 0, 1'b1));
                else
                begin
                    px[npart] = it.x_coord;
                    py[npart] = it.y_coord;
                    pcx[npart] = cell_of(it.x_coord, grid_w);
                    pcy[npart] = cell_of(it.y_coord, grid_h);
                    npart++;
                    add_expect(mk(KIND_ACK, 0, 1'b1));
                end
            end
            OP_QUERY:
            begin
                cx = cell_of(it.x_coord, grid_w);
                cy = cell_of(it.y_coord, grid_h);
                r2 = 128'(it.search_radius) * 128'(it.search_radius);
                hits = 0;
                for (int c = 0; c < 9; c++)
                    for (int p = 0; p < npart; p++)
                    begin
                        if (pcx[p] != cx - 1 + c / 3 || pcy[p] != cy - 1 + c % 3)
                            continue;
                        a = it.x_coord;
                        b = px[p];
                        dx = (a >= b) ? 128'(a - b) : 128'(b - a);
                        a = it.y_coord;
                        b = py[p];
                        dy = (a >= b) ? 128'(a - b) : 128'(b - a);
                        dsq = dx * dx + dy * dy;
                        if (dsq < r2)
                        begin
                            add_expect(mk(KIND_HIT, p, 1'b0));
                            hits++;
                        end
                    end
                if (hits == 0)
                    add_expect(mk(KIND_NONE, 0, 1'b1));
                else
                begin
                    o = expected_results.pop_back();
                    o.last = 1'b1;
                    add_expect(o);
                end
            end
            default:
                add_expect(mk(KIND_ACK, 0, 1'b1));
        endcase
    endtask

    task automatic send_item(input logic [1:0] op, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic [30:0] r);
        int gap;
        gap = $urandom_range(0, 4);
        repeat (gap) @(negedge clk);
        req.opcode = op;
        req.x_coord = x;
        req.y_coord = y;
        req.search_radius = r;
        req_valid = 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_results(req);
        items_sent++;
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic drain();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [30:0] val);
        drain();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CELL_WIDTH)
            grid_w = val;
        else
            grid_h = val;
    endtask

    // checker
    always @(posedge clk)
    begin
        rsp_taken <= rst_n && rsp_valid && rsp_ready;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result exp none act %p", $time, rsp);
                errors++;
            end
            else
            begin
                out_item_t e;
                e = expected_results.pop_front();
                if (e.kind == KIND_HIT)
                    hits_seen++;
                if (e.kind == KIND_FULL)
                    full_seen++;
                if (rsp.kind !== e.kind || rsp.neighbor_index !== e.neighbor_index ||
                    rsp.stored_count !== e.stored_count || rsp.last !== e.last)
                begin
                    $display("%0t: mismatch exp %p act %p", $time, e, rsp);
                    errors++;
                end
            end
        end
    end

    // receiver: long hold on request, else a random idle gap after each taken item
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rx_wait <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_cycles <= 3000;
            rsp_ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            rsp_ready <= (rx_wait == 1);
        end
        else if (rsp_taken)
        begin
            rx_draw = $urandom_range(0, 4);
            rx_wait <= rx_draw;
            rsp_ready <= (rx_draw == 0);
        end
        else
            rsp_ready <= 1'b1;
    end

    function automatic logic signed [31:0] rnd_near(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic test_directed();
        send_item(OP_QUERY, 0, 0, 31'h7fffffff);
        send_item(2'd3, 32'h7fffffff, 32'h80000000, 31'h7fffffff);
        send_item(OP_ADD, 32'h7fffffff, 32'h7fffffff, 31'd0);
        send_item(OP_ADD, 32'h80000000, 32'h80000000, 31'h7fffffff);
        send_item(OP_ADD, 0, 0, 31'd0);
        send_item(OP_ADD, -1, -1, 31'd0);
        send_item(OP_ADD, 32'h00008000, 32'hffff8000, 31'd0);
        send_item(OP_QUERY, 32'h7fffffff, 32'h7fffffff, 31'd1);
        send_item(OP_QUERY, 32'h7fffffff, 32'h7fffffff, 31'd0);
        send_item(OP_QUERY, 32'h80000000, 32'h80000000, 31'h7fffffff);
        send_item(OP_QUERY, 0, 0, 31'h7fffffff);
        send_item(OP_QUERY, 0, 0, 31'h00010000);
        send_item(OP_QUERY, 0, 0, 31'd0);
        send_item(OP_CLEAR, 32'hffffffff, 32'hffffffff, 31'h7fffffff);
        send_item(OP_QUERY, 0, 0, 31'h7fffffff);
    endtask

    task automatic test_fill_full();
        send_item(OP_CLEAR, 0, 0, 31'd0);
        for (int i = 0; i < 66; i++)
            send_item(OP_ADD, rnd_near(32'h30000), rnd_near(32'h30000), 31'($urandom));
        // receiver stalls while the sender keeps offering queries
        hold_req++;
        for (int i = 0; i < 4; i++)
            send_item(OP_QUERY, rnd_near(32'h20000), rnd_near(32'h20000), 31'h18000);
        drain();
    endtask

    task automatic test_random(input int n, input int span);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 3)
                send_item(OP_CLEAR, $urandom, $urandom, 31'($urandom));
            else if (k < 5)
                send_item(2'd3, $urandom, $urandom, 31'($urandom));
            else if (k < 8)
                send_item(2'($urandom_range(1, 2)), $urandom, $urandom, 31'($urandom));
            else if (k < 55)
                send_item(OP_ADD, rnd_near(span), rnd_near(span), 31'($urandom));
            else
                send_item(OP_QUERY, rnd_near(span), rnd_near(span),
                          31'($urandom_range(0, 2 * span)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = REG_CELL_WIDTH;
        cfg_data = '0;
        items_sent = 0;
        grid_w = 31'd65536;
        grid_h = 31'd65536;
        npart = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_fill_full();

        write_reg(REG_CELL_WIDTH, 31'h20000);
        write_reg(REG_CELL_HEIGHT, 31'h8000);
        test_random(120, 32'h40000);

        write_reg(REG_CELL_WIDTH, 31'd0);
        write_reg(REG_CELL_HEIGHT, 31'd0);
        send_item(OP_CLEAR, 0, 0, 31'd0);
        test_random(60, 40);

        write_reg(REG_CELL_WIDTH, 31'h7fffffff);
        write_reg(REG_CELL_HEIGHT, 31'h7fffffff);
        send_item(OP_CLEAR, 0, 0, 31'd0);
        test_random(60, 32'h7fffffff);

        write_reg(REG_CELL_WIDTH, 31'd1);
        write_reg(REG_CELL_HEIGHT, 31'h10000);
        test_random(60, 32'h20000);

        write_reg(REG_CELL_WIDTH, 31'($urandom));
        write_reg(REG_CELL_HEIGHT, 31'($urandom));
        test_random(100, 32'h80000);

        drain();
        repeat (1300) @(negedge clk);
        $display("Covered %0d items and %0d results (%0d hits, %0d store-full).",
                 items_sent, results_seen, hits_seen, full_seen);
        $display("Cell size settings included zero, one LSB and the maximum.");
        if (errors == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
